// ===== rtl/sliding_window_radius_outlier_filter_defines.svh =====
// Assertion macros shared by the radius outlier filter RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef SLIDING_WINDOW_RADIUS_OUTLIER_FILTER_DEFINES_SVH
`define SLIDING_WINDOW_RADIUS_OUTLIER_FILTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWROF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWROF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/swrof_pkg.sv =====
// Shared widths and constants of the radius outlier filter.
// No dependencies.
package swrof_pkg;

    localparam int COORD_W   = 32;
    localparam int RADIUS_W  = 32;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int THR_W     = 16;
    localparam int FRAC_W    = 16;

    localparam logic [THR_W-1:0] RATIO_RESET = 16'd6554;

endpackage

// ===== rtl/swrof_isqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
// Depends on swrof_pkg for the radicand and root widths.
module swrof_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [swrof_pkg::SQ_W-1:0]    i_radicand,
    output logic                          o_done,
    output logic [swrof_pkg::RADIUS_W-1:0] o_root
);
    import swrof_pkg::*;

    localparam int REM_W = RADIUS_W + 2;
    localparam int CNT_W = $clog2(RADIUS_W);

    logic [SQ_W-1:0]     r_rad;
    logic [REM_W-1:0]    r_rem;
    logic [RADIUS_W-1:0] r_root;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [REM_W-1:0]    w_shifted;
    logic [REM_W-1:0]    w_trial;
    logic                w_fits;

    // Bring down the next two radicand bits and try appending a one to the root.
    assign w_shifted = {r_rem[REM_W-3:0], r_rad[SQ_W-1 -: 2]};
    assign w_trial   = {r_root, 2'b01};
    assign w_fits    = (w_shifted >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rad  <= {r_rad[SQ_W-3:0], 2'b00};
                r_rem  <= w_fits ? (w_shifted - w_trial) : w_shifted;
                r_root <= {r_root[RADIUS_W-2:0], w_fits};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(RADIUS_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== rtl/sliding_window_radius_outlier_filter.sv =====
// One item is in flight at a time: a new item is taken only after the last one
// is committed, which waits for the 32-step bit-serial square root loop, and
// later while a finished result waits at the output.
// Reset (synchronous, active low) clears the window sum, fill count, slot,
// largest radius and handshakes and sets ratio_threshold to 6554; the radius
// history memory is not cleared, since the fill phase writes each entry first.
// Top level of the radius outlier filter; uses swrof_pkg and swrof_isqrt.
`include "sliding_window_radius_outlier_filter_defines.svh"

module sliding_window_radius_outlier_filter #(
    parameter int WINDOW = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration: ratio_threshold, Q0.16.
    input  logic                          i_cfg_we,
    input  logic [swrof_pkg::THR_W-1:0]   i_cfg_wdata,
    // Input stream.
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [63:0]                   i_s_axis_tdata,   // coord_x[31:0], coord_z[63:32]
    // Output stream.
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [63:0]                   o_m_axis_tdata,   // radius[31:0], max_radius[63:32]
    output logic                          o_m_axis_tuser    // is_good[0]
);
    import swrof_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = RADIUS_W + $clog2(WINDOW);
    localparam int TP_W   = THR_W + SUM_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQX,
        S_SQZ,
        S_ADD,
        S_ROOT,
        S_DIFF,
        S_DECIDE
    } t_state;

    t_state              r_state;
    logic [THR_W-1:0]    r_thr;
    logic [COORD_W-1:0]  r_ax;
    logic [COORD_W-1:0]  r_az;
    logic [SQ_W-1:0]     r_px;
    logic [SQ_W-1:0]     r_pz;
    logic [TP_W-1:0]     r_thr_prod;
    logic [RADIUS_W-1:0] r_diff;
    logic [SUM_W-1:0]    r_sum;
    logic [FILL_W-1:0]   r_fill;
    logic [SLOT_W-1:0]   r_slot;
    logic [RADIUS_W-1:0] r_max;
    logic [RADIUS_W-1:0] r_old;
    logic                r_out_valid;
    logic                r_out_good;
    logic [RADIUS_W-1:0] r_out_radius;
    logic [RADIUS_W-1:0] r_out_max;

    logic [RADIUS_W-1:0] r_hist [WINDOW];

    logic                w_accept;
    logic                w_out_free;
    logic                w_commit;
    logic                w_filling;
    logic                w_sq_start;
    logic                w_sq_done;
    logic [RADIUS_W-1:0] w_root;
    logic [COORD_W-1:0]  w_x;
    logic [COORD_W-1:0]  w_z;
    logic [RADIUS_W-1:0] w_new_max;

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_commit   = (r_state == S_DECIDE) && w_out_free;
    assign w_filling  = (r_fill < FILL_W'(WINDOW));
    assign w_sq_start = (r_state == S_ADD);
    assign w_new_max  = (w_root > r_max) ? w_root : r_max;

    // Two's-complement magnitude; the most negative value maps to 2^31 exactly.
    assign w_x = i_s_axis_tdata[COORD_W-1] ? (~i_s_axis_tdata[COORD_W-1:0] + 1'b1)
                                           : i_s_axis_tdata[COORD_W-1:0];
    assign w_z = i_s_axis_tdata[2*COORD_W-1] ? (~i_s_axis_tdata[2*COORD_W-1:COORD_W] + 1'b1)
                                             : i_s_axis_tdata[2*COORD_W-1:COORD_W];

    swrof_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sq_start),
        .i_radicand (r_px + r_pz),
        .o_done     (w_sq_done),
        .o_root     (w_root)
    );

    // The old radius is read when the item arrives and written back at commit,
    // so one item's read and write never overlap.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_old <= r_hist[r_slot];
        end
        if (w_commit) begin
            r_hist[r_slot] <= w_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= RATIO_RESET;
            r_sum       <= '0;
            r_fill      <= '0;
            r_slot      <= '0;
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_ax    <= w_x;
                        r_az    <= w_z;
                        r_state <= S_SQX;
                    end
                end
                S_SQX: begin
                    r_px       <= SQ_W'(r_ax) * SQ_W'(r_ax);
                    r_thr_prod <= TP_W'(r_thr) * TP_W'(r_sum);
                    r_state    <= S_SQZ;
                end
                S_SQZ: begin
                    r_pz    <= SQ_W'(r_az) * SQ_W'(r_az);
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (w_sq_done) begin
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_diff  <= (w_root >= r_old) ? (w_root - r_old) : (r_old - w_root);
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (w_out_free) begin
                        if (w_filling) begin
                            r_sum      <= r_sum + SUM_W'(w_root);
                            r_fill     <= r_fill + 1'b1;
                            r_out_good <= 1'b1;
                        end else begin
                            r_sum      <= r_sum - SUM_W'(r_old) + SUM_W'(w_root);
                            // A zero old sum flags any nonzero change.
                            r_out_good <= !(TP_W'({r_diff, FRAC_W'(0)}) > r_thr_prod);
                        end
                        r_slot       <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
                        r_max        <= w_new_max;
                        r_out_radius <= w_root;
                        r_out_max    <= w_new_max;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_max, r_out_radius};
    assign o_m_axis_tuser  = r_out_good;

    `SWROF_ASSERT_SAME(a_root_done_state, w_sq_done, r_state == S_ROOT, "root finished outside wait")
    `SWROF_ASSERT_SAME(a_fill_bound, 1'b1, r_fill <= FILL_W'(WINDOW), "fill count beyond window")
    `SWROF_ASSERT_SAME(a_slot_bound, 1'b1, r_slot <= SLOT_W'(WINDOW - 1), "slot beyond window")
    `SWROF_ASSERT_SAME(a_max_order, o_m_axis_tvalid, r_out_max >= r_out_radius, "max below radius")
    `SWROF_ASSERT_SAME(a_load_decide, $rose(o_m_axis_tvalid), $past(r_state) == S_DECIDE, "stray result")

endmodule

// ===== tb/swrof_result_checker.sv =====
// Result checker for the sliding-window radius outlier filter.
// Watches the config port and both streams, predicts each result and compares it.
// Depends on swrof_pkg for widths and the threshold reset value.
module swrof_result_checker #(
    parameter int WINDOW = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [swrof_pkg::THR_W-1:0] i_cfg_wdata,
    input  logic                        i_in_tvalid,
    input  logic                        i_in_tready,
    input  logic [63:0]                 i_in_tdata,     // coord_x[31:0], coord_z[63:32]
    input  logic                        i_out_tvalid,
    input  logic                        i_out_tready,
    input  logic [63:0]                 i_out_tdata,    // radius[31:0], max_radius[63:32]
    input  logic                        i_out_tuser,    // is_good[0]
    output int                          o_outstanding,
    output int                          o_fail_count
);
    import swrof_pkg::*;

    typedef struct packed {
        logic                good;
        logic [RADIUS_W-1:0] radius;
        logic [RADIUS_W-1:0] peak;
    } t_point_result;

    t_point_result       pending_results[$];

    // Shadow copy of the filter state.
    logic [RADIUS_W-1:0] radius_line [WINDOW];
    logic [63:0]         run_sum;
    int unsigned         fill_level;
    int unsigned         next_slot;
    logic [RADIUS_W-1:0] peak_radius;
    logic [THR_W-1:0]    ratio_thr;

    function automatic logic [COORD_W-1:0] coord_magnitude(input logic [COORD_W-1:0] v);
        // The most negative value maps to 2^31, which still fits unsigned.
        return v[COORD_W-1] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [RADIUS_W-1:0] floor_root(input logic [SQ_W-1:0] n);
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] acc;
        logic [SQ_W-1:0] probe;
        rem   = n;
        acc   = '0;
        probe = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (rem >= acc + probe) begin
                rem = rem - (acc + probe);
                acc = (acc >> 1) + probe;
            end else begin
                acc = acc >> 1;
            end
            probe = probe >> 2;
        end
        return acc[RADIUS_W-1:0];
    endfunction

    function automatic t_point_result classify_point(input logic [COORD_W-1:0] x,
                                                     input logic [COORD_W-1:0] z);
        logic [COORD_W-1:0]  ax;
        logic [COORD_W-1:0]  az;
        logic [SQ_W-1:0]     sq;
        logic [RADIUS_W-1:0] r;
        logic [RADIUS_W-1:0] oldr;
        logic [63:0]         old_sum;
        logic [63:0]         diff;
        t_point_result       res;
        ax = coord_magnitude(x);
        az = coord_magnitude(z);
        sq = {32'd0, ax} * {32'd0, ax} + {32'd0, az} * {32'd0, az};
        r  = floor_root(sq);
        res.good = 1'b1;
        if (r > peak_radius)
            peak_radius = r;
        if (fill_level < WINDOW) begin
            run_sum    = run_sum + {32'd0, r};
            fill_level = fill_level + 1;
        end else begin
            oldr    = radius_line[next_slot];
            old_sum = run_sum;
            diff    = (r >= oldr) ? {32'd0, r - oldr} : {32'd0, oldr - r};
            run_sum = old_sum - {32'd0, oldr} + {32'd0, r};
            // Cross-multiplied form of diff / old_sum > threshold; a zero sum
            // turns any change into an outlier.
            if ((diff << FRAC_W) > ({48'd0, ratio_thr} * old_sum))
                res.good = 1'b0;
        end
        radius_line[next_slot] = r;
        next_slot  = (next_slot + 1 >= WINDOW) ? 0 : next_slot + 1;
        res.radius = r;
        res.peak   = peak_radius;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
        o_fail_count = o_fail_count + 1;
    endtask

    always @(posedge i_clk) begin
        t_point_result want;
        if (!i_rst_n) begin
            pending_results.delete();
            run_sum     = '0;
            fill_level  = 0;
            next_slot   = 0;
            peak_radius = '0;
            ratio_thr   = RATIO_RESET;
        end else begin
            if (i_cfg_we)
                ratio_thr = i_cfg_wdata;
            if (i_in_tvalid && i_in_tready)
                pending_results.insert(pending_results.size(),
                                       classify_point(i_in_tdata[31:0], i_in_tdata[63:32]));
            if (i_out_tvalid && i_out_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result radius", i_out_tdata[31:0], '0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_out_tuser !== want.good)
                        report_mismatch("is_good", {31'd0, i_out_tuser}, {31'd0, want.good});
                    if (i_out_tdata[31:0] !== want.radius)
                        report_mismatch("radius", i_out_tdata[31:0], want.radius);
                    if (i_out_tdata[63:32] !== want.peak)
                        report_mismatch("max_radius", i_out_tdata[63:32], want.peak);
                end
            end
        end
        o_outstanding <= pending_results.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the radius outlier filter testbench: clock, reset, stimulus and verdict.
// Instantiates sliding_window_radius_outlier_filter and swrof_result_checker.
module testbench;
    import swrof_pkg::*;

    localparam int WINDOW        = 32;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 108;
    localparam int HOLD_AT       = 500;
    localparam int HOLD_CYCLES   = 400;
    localparam int TAIL_CYCLES   = 60;
    localparam int TIMEOUT       = 8_000_000;

    typedef enum int {SCN_STEADY, SCN_ZERO_RUN, SCN_WILD} t_scenario;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [THR_W-1:0]  cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [63:0]       s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [63:0]       m_tdata;
    logic              m_tuser;
    int                outstanding;
    int                fail_count;
    bit                no_idle   = 1'b0;

    always #6 clk = ~clk;

    sliding_window_radius_outlier_filter #(.WINDOW(WINDOW)) u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    swrof_result_checker #(.WINDOW(WINDOW)) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_tvalid   (s_tvalid),
        .i_in_tready   (s_tready),
        .i_in_tdata    (s_tdata),
        .i_out_tvalid  (m_tvalid),
        .i_out_tready  (m_tready),
        .i_out_tdata   (m_tdata),
        .i_out_tuser   (m_tuser),
        .o_outstanding (outstanding),
        .o_fail_count  (fail_count)
    );

    initial begin
        #(TIMEOUT);
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: random gaps per transfer, plus one long hold-off that
    // backs the filter up into its input.
    initial begin : result_sink
        int gap;
        int taken;
        taken = 0;
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 19);
            if (taken == HOLD_AT)
                gap = HOLD_CYCLES;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            taken++;
        end
    end

    task automatic send_point(input logic [31:0] x, input logic [31:0] z);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, x};
        do @(posedge clk); while (!s_tready);
    endtask

    // Must be called in the step right after a transfer so that valid drops
    // before the next edge.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] v);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] signed_span(input int bits);
        logic [31:0] v;
        v = $urandom() & ((32'd1 << bits) - 32'd1);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic logic [31:0] wild_coord();
        case ($urandom_range(0, 19))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    initial begin : stimulus
        logic [31:0] dir_x [20];
        logic [31:0] dir_z [20];
        logic [31:0] bx;
        logic [31:0] bz;
        logic [THR_W-1:0] thr;
        t_scenario   scn;
        int          span;
        int          jsh;
        int          roll;
        int          zero_left;

        // Opening fill items, mostly in order of growing radius so the peak moves several times.
        dir_x = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF,
                  32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000,
                  32'h0003_0000, 32'hFFFD_0000, 32'h7FFF_0000, 32'h7FFF_FFFF,
                  32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'h5555_5555,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        dir_z = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000,
                  32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000,
                  32'h0004_0000, 32'h0004_0000, 32'h0000_0001, 32'h0000_0000,
                  32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'hAAAA_AAAA,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 20; i++)
            send_point(dir_x[i], dir_z[i]);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph)
                0:       thr = '0;
                1:       thr = 16'hFFFF;
                2:       thr = RATIO_RESET;
                default: thr = THR_W'($urandom_range(0, 1) ? $urandom_range(0, 400)
                                                           : $urandom_range(0, 65535));
            endcase
            write_threshold(thr);
            no_idle = (ph % 4 == 1);
            if (ph == 3 || ph == 9)
                scn = SCN_ZERO_RUN;
            else if (ph == 2 || ph == 7 || ph == 11)
                scn = SCN_WILD;
            else
                scn = SCN_STEADY;
            zero_left = 34;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case (scn)
                    SCN_STEADY: begin
                        // A cluster of points around one base, redrawn now and then.
                        if (n % 40 == 0) begin
                            span = $urandom_range(4, 30);
                            bx   = signed_span(span);
                            bz   = signed_span(span);
                            jsh  = (span > 8) ? span - $urandom_range(1, 8) : 0;
                        end
                        roll = $urandom_range(0, 99);
                        if (roll < 8)
                            send_point(wild_coord(), wild_coord());
                        else if (roll < 12)
                            send_point('0, '0);
                        else
                            send_point(bx + signed_span(jsh), bz + signed_span(jsh));
                    end
                    SCN_ZERO_RUN: begin
                        // Long zero runs empty the window sum; the probe after
                        // each run meets a sum of zero.
                        if (zero_left > 0) begin
                            send_point('0, '0);
                            zero_left--;
                        end else begin
                            case ($urandom_range(0, 3))
                                0:       send_point('0, '0);
                                1:       send_point(32'h0000_0001, '0);
                                2:       send_point('0, 32'hFFFF_FFFF);
                                default: send_point(signed_span(20), signed_span(20));
                            endcase
                            zero_left = 32 + $urandom_range(0, 3);
                        end
                    end
                    default: send_point(wild_coord(), wild_coord());
                endcase
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
